// File: sv/lhm_pkg.sv
package lhm_pkg;

    // health codes
    localparam logic [2:0] HEALTH_UNINIT   = 3'd0;
    localparam logic [2:0] HEALTH_TRACKING = 3'd1;
    localparam logic [2:0] HEALTH_DEGRADED = 3'd2;
    localparam logic [2:0] HEALTH_LOST     = 3'd3;
    localparam logic [2:0] HEALTH_RELOC    = 3'd4;
    localparam logic [2:0] HEALTH_RECOVER  = 3'd5;

    // event codes
    localparam logic [2:0] OP_ACCEPT    = 3'd0;
    localparam logic [2:0] OP_REJECT    = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_BEGIN     = 3'd3;
    localparam logic [2:0] OP_CANDIDATE = 3'd4;
    localparam logic [2:0] OP_CONFIRM   = 3'd5;
    localparam logic [2:0] OP_FAIL      = 3'd6;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DEGRADE_FAIL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOSE_FAIL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRUST_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_FRAME = 2'd3;

    // configuration reset values
    localparam logic [7:0]  RST_DEGRADE_FAIL  = 8'd1;
    localparam logic [7:0]  RST_LOSE_FAIL     = 8'd3;
    localparam logic [31:0] RST_TRUST_TIMEOUT = 32'd1000;
    localparam logic [7:0]  RST_RECOVER_FRAME = 8'd3;

    localparam logic [7:0] RUN_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic        motion_ok;
    } in_t;

    typedef struct packed {
        logic [2:0]  health;
        logic        pose_valid;
        logic        event_ok;
        logic [31:0] trusted_ms;
        logic        trusted_seen;
    } out_t;

    // effective (clamped) thresholds
    typedef struct packed {
        logic [7:0]  degrade_fail;
        logic [7:0]  lose_fail;
        logic [31:0] trust_timeout;
        logic [7:0]  recover_frame;
    } cfg_t;

endpackage

// File: sv/lock_health_monitor_fsm.sv
// Lock health monitor: six-state health tracker for a localizer lock.
// Input channel (s_valid / s_ready / s_data) carries one timed event per
// request: operation code, timestamp in ms and the motion flag for confirm.
// Result channel (m_valid / m_ready / m_data) returns exactly one status
// request per event: health, pose valid, event ok, last trusted time and
// the trusted-seen flag, all showing the state after that event.
// Thresholds are set through the write port (cfg_wr_en, cfg_index,
// cfg_data); the user must write only while no event is in flight, which
// the block itself does not enforce; writes take effect at once. An
// accepted event passes through the input register, then the event
// decode and state update into the result register, which drives m_valid.
// One event per cycle is taken while the receiver does not stall.
// When the receiver stalls the result register holds its request, the input
// register takes one more event, and s_ready then drops until m_ready.
// Synchronous reset (aresetn low) clears both channels, sets the health to
// uninitialized with no trusted time, and restores the threshold defaults.
module lock_health_monitor_fsm (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lhm_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lhm_pkg::out_t                    m_data,
    input  logic                             cfg_wr_en,
    input  logic [lhm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic          in_valid_reg;
    lhm_pkg::in_t  in_data_reg;
    logic          out_valid_reg;
    lhm_pkg::out_t out_data_reg;
    logic          advance;
    logic          fire;
    lhm_pkg::cfg_t cfg;
    lhm_pkg::out_t result;

    // handshake control
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    lhm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lhm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: sv/lhm_cfg_regs.sv
module lhm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lhm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lhm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lhm_pkg::cfg_t                    cfg
);

    logic [7:0]  degrade_fail_reg;
    logic [7:0]  lose_fail_reg;
    logic [31:0] trust_timeout_reg;
    logic [7:0]  recover_frame_reg;
    logic [7:0]  degrade_eff;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degrade_fail_reg  <= lhm_pkg::RST_DEGRADE_FAIL;
            lose_fail_reg     <= lhm_pkg::RST_LOSE_FAIL;
            trust_timeout_reg <= lhm_pkg::RST_TRUST_TIMEOUT;
            recover_frame_reg <= lhm_pkg::RST_RECOVER_FRAME;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lhm_pkg::REG_DEGRADE_FAIL:  degrade_fail_reg  <= cfg_data[7:0];
                lhm_pkg::REG_LOSE_FAIL:     lose_fail_reg     <= cfg_data[7:0];
                lhm_pkg::REG_TRUST_TIMEOUT: trust_timeout_reg <= cfg_data[31:0];
                lhm_pkg::REG_RECOVER_FRAME: recover_frame_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamp thresholds: degrade >= 1, lose >= degrade, recover >= 1
    always_comb begin
        degrade_eff = (degrade_fail_reg == 8'd0) ? 8'd1 : degrade_fail_reg;
        cfg.degrade_fail  = degrade_eff;
        cfg.lose_fail     = (lose_fail_reg < degrade_eff) ? degrade_eff : lose_fail_reg;
        cfg.trust_timeout = trust_timeout_reg;
        cfg.recover_frame = (recover_frame_reg == 8'd0) ? 8'd1 : recover_frame_reg;
    end

endmodule

// File: sv/lhm_core.sv
module lhm_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  lhm_pkg::in_t   item,
    input  lhm_pkg::cfg_t  cfg,
    output lhm_pkg::out_t  result
);

    logic [2:0]  health_reg, health_next;
    logic [7:0]  fail_run_reg, fail_run_next;
    logic [7:0]  recover_run_reg, recover_run_next;
    logic [31:0] trust_time_reg, trust_time_next;
    logic        trust_seen_reg, trust_seen_next;
    logic        ok;
    logic        locked;
    logic [7:0]  fail_inc;
    logic [7:0]  recover_inc;
    logic [31:0] age;
    logic        timed_out;

    // state registers, updated once per event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            health_reg      <= lhm_pkg::HEALTH_UNINIT;
            fail_run_reg    <= 8'd0;
            recover_run_reg <= 8'd0;
            trust_time_reg  <= 32'd0;
            trust_seen_reg  <= 1'b0;
        end else if (fire) begin
            health_reg      <= health_next;
            fail_run_reg    <= fail_run_next;
            recover_run_reg <= recover_run_next;
            trust_time_reg  <= trust_time_next;
            trust_seen_reg  <= trust_seen_next;
        end
    end

    // shared terms
    always_comb begin
        locked = (health_reg == lhm_pkg::HEALTH_TRACKING) ||
                 (health_reg == lhm_pkg::HEALTH_DEGRADED);
        fail_inc    = (fail_run_reg == lhm_pkg::RUN_MAX) ? fail_run_reg : fail_run_reg + 8'd1;
        recover_inc = (recover_run_reg == lhm_pkg::RUN_MAX) ?
                      recover_run_reg : recover_run_reg + 8'd1;
        // signed age: a negative age never times out
        age       = item.now_ms - trust_time_reg;
        timed_out = trust_seen_reg && !age[31] && ({1'b0, age[30:0]} > cfg.trust_timeout);
    end

    // event decode and next state
    always_comb begin
        health_next      = health_reg;
        fail_run_next    = fail_run_reg;
        recover_run_next = recover_run_reg;
        trust_time_next  = trust_time_reg;
        trust_seen_next  = trust_seen_reg;
        ok               = 1'b0;
        unique case (item.operation)
            lhm_pkg::OP_ACCEPT: begin
                health_next      = lhm_pkg::HEALTH_TRACKING;
                fail_run_next    = 8'd0;
                recover_run_next = 8'd0;
                trust_time_next  = item.now_ms;
                trust_seen_next  = 1'b1;
            end
            lhm_pkg::OP_REJECT: begin
                if (locked) begin
                    fail_run_next = fail_inc;
                    if (fail_inc >= cfg.lose_fail) begin
                        health_next      = lhm_pkg::HEALTH_LOST;
                        fail_run_next    = 8'd0;
                        recover_run_next = 8'd0;
                    end else if (timed_out) begin
                        health_next      = lhm_pkg::HEALTH_LOST;
                        fail_run_next    = 8'd0;
                        recover_run_next = 8'd0;
                    end else if (fail_inc >= cfg.degrade_fail) begin
                        health_next = lhm_pkg::HEALTH_DEGRADED;
                    end
                end
            end
            lhm_pkg::OP_TICK: begin
                if (locked && timed_out) begin
                    health_next      = lhm_pkg::HEALTH_LOST;
                    fail_run_next    = 8'd0;
                    recover_run_next = 8'd0;
                end
            end
            lhm_pkg::OP_BEGIN: begin
                if (health_reg != lhm_pkg::HEALTH_RELOC &&
                    health_reg != lhm_pkg::HEALTH_RECOVER) begin
                    health_next      = lhm_pkg::HEALTH_RELOC;
                    fail_run_next    = 8'd0;
                    recover_run_next = 8'd0;
                    ok               = 1'b1;
                end
            end
            lhm_pkg::OP_CANDIDATE: begin
                if (health_reg == lhm_pkg::HEALTH_RELOC) begin
                    health_next      = lhm_pkg::HEALTH_RECOVER;
                    recover_run_next = 8'd0;
                    ok               = 1'b1;
                end
            end
            lhm_pkg::OP_CONFIRM: begin
                if (health_reg == lhm_pkg::HEALTH_RECOVER) begin
                    if (!item.motion_ok) begin
                        recover_run_next = 8'd0;
                    end else if (recover_inc >= cfg.recover_frame) begin
                        health_next      = lhm_pkg::HEALTH_TRACKING;
                        fail_run_next    = 8'd0;
                        recover_run_next = 8'd0;
                        trust_time_next  = item.now_ms;
                        trust_seen_next  = 1'b1;
                        ok               = 1'b1;
                    end else begin
                        recover_run_next = recover_inc;
                    end
                end
            end
            lhm_pkg::OP_FAIL: begin
                health_next      = lhm_pkg::HEALTH_LOST;
                fail_run_next    = 8'd0;
                recover_run_next = 8'd0;
            end
            default: ;
        endcase
    end

    // status after the event
    always_comb begin
        result.health       = health_next;
        result.pose_valid   = trust_seen_next &&
                              ((health_next == lhm_pkg::HEALTH_TRACKING) ||
                               (health_next == lhm_pkg::HEALTH_DEGRADED));
        result.event_ok     = ok;
        result.trusted_ms   = trust_time_next;
        result.trusted_seen = trust_seen_next;
    end

endmodule

// File: sv/lhm_checker.sv
module lhm_sva_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  lhm_pkg::out_t                    m_data
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // pose valid only with a trusted time while locked
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pose_valid |->
            m_data.trusted_seen &&
            (m_data.health == lhm_pkg::HEALTH_TRACKING ||
             m_data.health == lhm_pkg::HEALTH_DEGRADED))
        else $error("pose valid without lock");

    // a successful event lands in relocalizing, recovering or tracking
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_ok |->
            (m_data.health == lhm_pkg::HEALTH_RELOC ||
             m_data.health == lhm_pkg::HEALTH_RECOVER ||
             m_data.health == lhm_pkg::HEALTH_TRACKING))
        else $error("event ok with unexpected health");

    // once trusted, health never reads uninitialized
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.trusted_seen |-> m_data.health != lhm_pkg::HEALTH_UNINIT)
        else $error("uninitialized health after a trusted result");

endmodule

bind lock_health_monitor_fsm lhm_sva_checker u_lhm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
